// ----- rtl/qsam_pkg.sv -----
`timescale 1ns / 1ps

package qsam_pkg;

	localparam int CHANNEL_BITS_DEF = 12;

	localparam int CENTER_W = 12;
	localparam int HOLD_W = 16;
	localparam int STICK_W = 12;
	localparam int MOTOR_W = 13;
	localparam int QUARTER_W = 10;
	localparam int MOTORS = 4;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam int THROTTLE_MIN = 4;
	localparam int THROTTLE_MAX = 4000;
	localparam int STICK_LIMIT = 2000;
	localparam int GESTURE_LEVEL = 1950;

	localparam int MOTOR_OFF = 4000;
	localparam int MOTOR_MIN = 4400;
	localparam int MOTOR_MAX = 8000;

	localparam logic [CENTER_W-1:0] YAW_CENTER_RST = CENTER_W'(2050);
	localparam logic [CENTER_W-1:0] PITCH_CENTER_RST = CENTER_W'(2065);
	localparam logic [CENTER_W-1:0] ROLL_CENTER_RST = CENTER_W'(2110);
	localparam logic [HOLD_W-1:0] ARM_HOLD_RST = HOLD_W'(2000);

	typedef enum logic [1:0] {
		REG_YAW_CENTER,
		REG_PITCH_CENTER,
		REG_ROLL_CENTER,
		REG_ARM_HOLD
	} reg_idx_t;

	typedef struct packed {
		logic [CENTER_W-1:0] yaw_center;
		logic [CENTER_W-1:0] pitch_center;
		logic [CENTER_W-1:0] roll_center;
		logic [HOLD_W-1:0]   arm_hold_ticks;
	} cfg_t;

	typedef struct packed {
		logic [STICK_W-1:0]        throttle;
		logic signed [STICK_W-1:0] yaw;
		logic signed [STICK_W-1:0] pitch;
		logic signed [STICK_W-1:0] roll;
	} sticks_t;

	typedef logic [MOTORS-1:0][MOTOR_W-1:0] mix_t;

	function automatic logic arm_gesture(input sticks_t s);
		return (s.throttle == '0) && (s.yaw >= GESTURE_LEVEL) &&
			(s.pitch <= -GESTURE_LEVEL) && (s.roll >= GESTURE_LEVEL);
	endfunction

	function automatic logic disarm_gesture(input sticks_t s);
		return (s.throttle == '0) && (s.yaw <= -GESTURE_LEVEL) &&
			(s.pitch <= -GESTURE_LEVEL) && (s.roll <= -GESTURE_LEVEL);
	endfunction

	function automatic logic [MOTOR_W-1:0] clamp_motor(input logic [MOTOR_W-1:0] m);
		logic [MOTOR_W-1:0] r;
		r = m;
		if (m > MOTOR_W'(MOTOR_MAX)) r = MOTOR_W'(MOTOR_MAX);
		if (m < MOTOR_W'(MOTOR_MIN)) r = MOTOR_W'(MOTOR_MIN);
		return r;
	endfunction

endpackage

// ----- rtl/qsam_cfg.sv -----
`timescale 1ns / 1ps

module qsam_cfg import qsam_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx = reg_idx_t'(paddr[3:2]);
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.yaw_center <= YAW_CENTER_RST;
			cfg_q.pitch_center <= PITCH_CENTER_RST;
			cfg_q.roll_center <= ROLL_CENTER_RST;
			cfg_q.arm_hold_ticks <= ARM_HOLD_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_YAW_CENTER:   cfg_q.yaw_center <= pwdata[CENTER_W-1:0];
				REG_PITCH_CENTER: cfg_q.pitch_center <= pwdata[CENTER_W-1:0];
				REG_ROLL_CENTER:  cfg_q.roll_center <= pwdata[CENTER_W-1:0];
				REG_ARM_HOLD:     cfg_q.arm_hold_ticks <= pwdata[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_YAW_CENTER:   prdata = APB_DATA_W'(cfg_q.yaw_center);
			REG_PITCH_CENTER: prdata = APB_DATA_W'(cfg_q.pitch_center);
			REG_ROLL_CENTER:  prdata = APB_DATA_W'(cfg_q.roll_center);
			REG_ARM_HOLD:     prdata = APB_DATA_W'(cfg_q.arm_hold_ticks);
			default:          prdata = '0;
		endcase
	end

endmodule

// ----- rtl/qsam_cond.sv -----
`timescale 1ns / 1ps

module qsam_cond import qsam_pkg::*; #(
	parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
	input  logic [CHANNEL_BITS-1:0] raw_throttle,
	input  logic [CHANNEL_BITS-1:0] raw_yaw,
	input  logic [CHANNEL_BITS-1:0] raw_pitch,
	input  logic [CHANNEL_BITS-1:0] raw_roll,
	input  cfg_t                    cfg,
	output sticks_t                 sticks
);

	localparam int DIFF_W = ((CHANNEL_BITS > CENTER_W) ? CHANNEL_BITS : CENTER_W) + 1;

	// center offset, deadband (lo < v < hi reads as zero; lo and hi may differ), clamp
	function automatic logic signed [STICK_W-1:0] shape(
		input logic signed [DIFF_W-1:0] v,
		input int lo,
		input int hi
	);
		logic signed [DIFF_W-1:0] r;
		r = v;
		if (v > lo && v < hi) r = '0;
		if (r > STICK_LIMIT) r = DIFF_W'(STICK_LIMIT);
		if (r < -STICK_LIMIT) r = DIFF_W'(-STICK_LIMIT);
		return r[STICK_W-1:0];
	endfunction

	logic signed [DIFF_W-1:0] diff_yaw;
	logic signed [DIFF_W-1:0] diff_pitch;
	logic signed [DIFF_W-1:0] diff_roll;

	assign diff_yaw = $signed(DIFF_W'(raw_yaw)) - $signed(DIFF_W'(cfg.yaw_center));
	assign diff_pitch = $signed(DIFF_W'(raw_pitch)) - $signed(DIFF_W'(cfg.pitch_center));
	assign diff_roll = $signed(DIFF_W'(raw_roll)) - $signed(DIFF_W'(cfg.roll_center));

	always_comb begin
		if (raw_throttle < THROTTLE_MIN) begin
			sticks.throttle = '0;
		end else if (raw_throttle > THROTTLE_MAX) begin
			sticks.throttle = STICK_W'(THROTTLE_MAX);
		end else begin
			sticks.throttle = STICK_W'(raw_throttle);
		end
		sticks.yaw = shape(diff_yaw, -6, 8);
		sticks.pitch = shape(diff_pitch, -4, 8);
		sticks.roll = shape(diff_roll, -5, 5);
	end

endmodule

// ----- rtl/qsam_mix.sv -----
`timescale 1ns / 1ps

module qsam_mix import qsam_pkg::*; (
	input  sticks_t sticks,
	output mix_t    mix
);

	localparam int SUM_W = MOTOR_W + 2;
	localparam int T5_W = 15;

	// divide by 4, truncating toward zero
	function automatic logic signed [QUARTER_W-1:0] quarter(input logic signed [STICK_W-1:0] v);
		logic signed [STICK_W:0] a;
		a = $signed({v[STICK_W-1], v}) + (v[STICK_W-1] ? (STICK_W+1)'(3) : '0);
		return QUARTER_W'(a >>> 2);
	endfunction

	logic [T5_W-1:0]                t5;
	logic [MOTOR_W-1:0]             base;
	logic signed [SUM_W-1:0]        base_s;
	logic signed [SUM_W-1:0]        qy;
	logic signed [SUM_W-1:0]        qp;
	logic signed [SUM_W-1:0]        qr;
	logic signed [MOTORS-1:0][SUM_W-1:0] sum;

	// throttle / 1.6 as floor(throttle * 5 / 8)
	assign t5 = T5_W'({sticks.throttle, 2'b00}) + T5_W'(sticks.throttle);
	assign base = MOTOR_W'(MOTOR_OFF) + MOTOR_W'(t5 >> 3);
	assign base_s = $signed(SUM_W'(base));
	assign qy = SUM_W'(quarter(sticks.yaw));
	assign qp = SUM_W'(quarter(sticks.pitch));
	assign qr = SUM_W'(quarter(sticks.roll));

	assign sum[0] = base_s - qp - qr + qy;
	assign sum[1] = base_s + qp + qr + qy;
	assign sum[2] = base_s - qp + qr - qy;
	assign sum[3] = base_s + qp - qr - qy;

	always_comb begin
		for (int i = 0; i < MOTORS; i++) begin
			mix[i] = sum[i][MOTOR_W-1:0];
		end
	end

endmodule

// ----- rtl/quad_stick_arming_motor_mixer_top.sv -----
`timescale 1ns / 1ps

// X-frame quad motor mixer with stick arming. Each input transaction is a receiver frame
// (kind 0) or a control tick (kind 1) and yields exactly one output transaction carrying
// the four motor compare values and the armed flag as they stand after it. A frame
// conditions and holds the sticks and may disarm at once; a tick advances the arming
// hold and recomputes the mixer. The input register feeds one pass of conditioning,
// gesture, hold and mixer logic into the output register, so a transaction is taken
// every cycle; only out_stall slows the block. Motors read 4000 while disarmed and
// 4400..8000 while armed. The user must write the centers and the hold length through
// the APB port only while no transaction is in flight; the block does not enforce it.
module quad_stick_arming_motor_mixer_top import qsam_pkg::*; #(
	parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    kind,
	input  logic [CHANNEL_BITS-1:0] raw_throttle,
	input  logic [CHANNEL_BITS-1:0] raw_yaw,
	input  logic [CHANNEL_BITS-1:0] raw_pitch,
	input  logic [CHANNEL_BITS-1:0] raw_roll,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [MOTOR_W-1:0]      motor_one,
	output logic [MOTOR_W-1:0]      motor_two,
	output logic [MOTOR_W-1:0]      motor_three,
	output logic [MOTOR_W-1:0]      motor_four,
	output logic                    armed,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [APB_ADDR_W-1:0]   paddr,
	input  logic [APB_DATA_W-1:0]   pwdata,
	output logic [APB_DATA_W-1:0]   prdata,
	output logic                    pready
);

	cfg_t cfg;

	logic                    valid_s1;
	logic                    kind_s1;
	logic [CHANNEL_BITS-1:0] raw_throttle_s1;
	logic [CHANNEL_BITS-1:0] raw_yaw_s1;
	logic [CHANNEL_BITS-1:0] raw_pitch_s1;
	logic [CHANNEL_BITS-1:0] raw_roll_s1;

	sticks_t            sticks_q;
	mix_t               mix_q;
	logic               armed_flag_q;
	logic [HOLD_W-1:0]  hold_q;

	logic               out_valid_q;
	mix_t               motor_q;
	logic               armed_q;

	sticks_t            frame_sticks;
	sticks_t            sticks_n;
	mix_t               mix_calc;
	mix_t               mix_n;
	mix_t               motor_n;
	logic               armed_n;
	logic [HOLD_W-1:0]  hold_n;
	logic [HOLD_W-1:0]  hold_inc;
	logic               disarm;
	logic               advance;

	qsam_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	qsam_cond #(
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_cond (
		.raw_throttle (raw_throttle_s1),
		.raw_yaw      (raw_yaw_s1),
		.raw_pitch    (raw_pitch_s1),
		.raw_roll     (raw_roll_s1),
		.cfg          (cfg),
		.sticks       (frame_sticks)
	);

	// ticks mix the held sticks, which a tick never changes
	qsam_mix u_mix (
		.sticks (sticks_q),
		.mix    (mix_calc)
	);

	assign advance = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_comb begin
		sticks_n = kind_s1 ? sticks_q : frame_sticks;
		disarm = armed_flag_q && disarm_gesture(sticks_n);
		armed_n = armed_flag_q && !disarm;
		hold_n = disarm ? '0 : hold_q;
		hold_inc = (hold_n == '1) ? hold_n : hold_n + 1'b1;
		if (kind_s1) begin
			if (armed_n) begin
				hold_n = '0;
			end else if (arm_gesture(sticks_n)) begin
				if (hold_inc >= cfg.arm_hold_ticks) begin
					armed_n = 1'b1;
					hold_n = '0;
				end else begin
					hold_n = hold_inc;
				end
			end else begin
				hold_n = '0;
			end
		end
		mix_n = kind_s1 ? mix_calc : mix_q;
		for (int i = 0; i < MOTORS; i++) begin
			motor_n[i] = armed_n ? clamp_motor(mix_n[i]) : MOTOR_W'(MOTOR_OFF);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			kind_s1 <= kind;
			raw_throttle_s1 <= raw_throttle;
			raw_yaw_s1 <= raw_yaw;
			raw_pitch_s1 <= raw_pitch;
			raw_roll_s1 <= raw_roll;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sticks_q <= '0;
			for (int i = 0; i < MOTORS; i++) begin
				mix_q[i] <= MOTOR_W'(MOTOR_OFF);
			end
			armed_flag_q <= 1'b0;
			hold_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				sticks_q <= sticks_n;
				mix_q <= mix_n;
				armed_flag_q <= armed_n;
				hold_q <= hold_n;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			motor_q <= motor_n;
			armed_q <= armed_n;
		end
	end

	assign out_valid = out_valid_q;
	assign motor_one = motor_q[0];
	assign motor_two = motor_q[1];
	assign motor_three = motor_q[2];
	assign motor_four = motor_q[3];
	assign armed = armed_q;

	a_disarmed_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !armed_q |-> motor_one == MOTOR_W'(MOTOR_OFF) &&
			motor_two == MOTOR_W'(MOTOR_OFF) && motor_three == MOTOR_W'(MOTOR_OFF) &&
			motor_four == MOTOR_W'(MOTOR_OFF))
		else $error("disarmed result with motors not idle");

	a_armed_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && armed_q |-> motor_one >= MOTOR_W'(MOTOR_MIN) &&
			motor_one <= MOTOR_W'(MOTOR_MAX) && motor_four >= MOTOR_W'(MOTOR_MIN) &&
			motor_four <= MOTOR_W'(MOTOR_MAX))
		else $error("armed motor value out of range");

	a_hold_disarmed: assert property (@(posedge clk) disable iff (!arst_n)
		hold_q != '0 |-> !armed_flag_q)
		else $error("arming hold count running while armed");

	a_flag_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> armed_q == armed_flag_q)
		else $error("reported armed flag differs from state");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && out_stall |=> valid_s1 && $stable(kind_s1))
		else $error("transaction lost in input register");

endmodule
